### rtl/core/sis_pkg.sv
package sis_pkg;

  localparam int LEN_W       = 9;
  localparam int SEED_W      = 32;
  localparam int MAX_CHUNK_D = 256;
  localparam int TAB_N       = 32;
  localparam int TAB_W       = $clog2(TAB_N);

  localparam logic [SEED_W-1:0] LFSR_TAPS  = 32'hC000_0401;
  localparam logic [LEN_W-1:0]  PRIME_BASE = 9'd11;
  localparam logic [LEN_W-1:0]  STEP_SUB   = 9'd4;
  localparam logic [LEN_W-1:0]  STEP_ADD   = 9'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  prime;
    logic [LEN_W-1:0]  size;
    logic [LEN_W-1:0]  pos;
    logic [LEN_W-1:0]  step;
    logic [SEED_W-1:0] seed;
  } sis_start_t;

  typedef struct packed {
    logic [LEN_W-1:0] pos_nxt;
    logic [LEN_W-1:0] done_nxt;
    logic             decoy;
    logic             last;
  } sis_walk_t;

  function automatic logic [LEN_W-1:0] prime_lookup(input logic [TAB_W-1:0] idx);
    logic [LEN_W-1:0] p;
    case (idx)
      5'd0:    p = 9'd11;
      5'd1:    p = 9'd23;
      5'd2:    p = 9'd29;
      5'd3:    p = 9'd37;
      5'd4:    p = 9'd47;
      5'd5:    p = 9'd59;
      5'd6:    p = 9'd61;
      5'd7:    p = 9'd71;
      5'd8:    p = 9'd79;
      5'd9:    p = 9'd89;
      5'd10:   p = 9'd97;
      5'd11:   p = 9'd103;
      5'd12:   p = 9'd109;
      5'd13:   p = 9'd127;
      5'd14:   p = 9'd131;
      5'd15:   p = 9'd137;
      5'd16:   p = 9'd149;
      5'd17:   p = 9'd157;
      5'd18:   p = 9'd163;
      5'd19:   p = 9'd173;
      5'd20:   p = 9'd179;
      5'd21:   p = 9'd191;
      5'd22:   p = 9'd193;
      5'd23:   p = 9'd199;
      5'd24:   p = 9'd211;
      5'd25:   p = 9'd223;
      5'd26:   p = 9'd227;
      5'd27:   p = 9'd233;
      5'd28:   p = 9'd241;
      5'd29:   p = 9'd251;
      5'd30:   p = 9'd257;
      5'd31:   p = 9'd263;
      default: p = 9'd11;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/sis_start_calc.sv
module sis_start_calc import sis_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_D
) (
  input  logic [LEN_W-1:0]  chunk_len,
  input  logic              use_new_seed,
  input  logic [SEED_W-1:0] seed_in,
  input  logic [SEED_W-1:0] seed_cur,
  output sis_start_t        start
);

  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        len_m1;
  logic [SEED_W-1:0]       seed0;
  logic [SEED_W-1:0]       seed1;
  logic [LEN_W-1:0]        prime;
  logic [LEN_W-1:0]        prime_m4;
  logic [LEN_W+SEED_W-1:0] prod_pos;
  logic [LEN_W+SEED_W-1:0] prod_step;

  always_comb begin
    if (chunk_len == '0) begin
      len = LEN_W'(1);
    end else if (chunk_len > LEN_W'(MAX_CHUNK)) begin
      len = LEN_W'(MAX_CHUNK);
    end else begin
      len = chunk_len;
    end
  end

  assign len_m1    = len - LEN_W'(1);
  assign prime     = prime_lookup(len_m1[TAB_W+2:3]);
  assign prime_m4  = prime - STEP_SUB;
  assign seed0     = use_new_seed ? seed_in : seed_cur;
  assign seed1     = {seed0[SEED_W-2:0], 1'b0} ^ (seed0[SEED_W-1] ? '0 : LFSR_TAPS);
  assign prod_pos  = {{SEED_W{1'b0}}, prime} * {{LEN_W{1'b0}}, seed0};
  assign prod_step = {{SEED_W{1'b0}}, prime_m4} * {{LEN_W{1'b0}}, seed1};

  assign start.prime = prime;
  assign start.size  = len;
  assign start.pos   = prod_pos[LEN_W+SEED_W-1:SEED_W];
  assign start.step  = prod_step[LEN_W+SEED_W-1:SEED_W] + STEP_ADD;
  assign start.seed  = seed1;

endmodule

### rtl/core/sis_walk.sv
module sis_walk import sis_pkg::*; (
  input  logic [LEN_W-1:0] cur_pos,
  input  logic [LEN_W-1:0] step_size,
  input  logic [LEN_W-1:0] chunk_size,
  input  logic [LEN_W-1:0] modulus_prime,
  input  logic [LEN_W-1:0] real_done,
  output sis_walk_t        walk
);

  logic [LEN_W:0]   sum;
  logic [LEN_W:0]   wrap;
  logic [LEN_W-1:0] done_inc;
  logic             decoy;

  assign decoy    = cur_pos >= chunk_size;
  assign done_inc = real_done + LEN_W'(1);
  assign sum      = {1'b0, cur_pos} + {1'b0, step_size};
  assign wrap     = (sum >= {1'b0, modulus_prime}) ? sum - {1'b0, modulus_prime} : sum;

  assign walk.pos_nxt  = wrap[LEN_W-1:0];
  assign walk.decoy    = decoy;
  assign walk.done_nxt = decoy ? real_done : done_inc;
  assign walk.last     = !decoy && (done_inc == chunk_size);

endmodule

### rtl/core/shuffled_index_sequencer_core.sv
// Shuffled index sequencer. Each input word is either a chunk start (tuser 0) or a request
// for the next position (tuser 1), and each gives exactly one result word. One word is
// taken per clock while the output is not stalled; a word's result is presented after it
// passes through an input register and a result register, with the start calculation
// (prime table lookup and two 9x32 multipliers) and the position step (add and conditional
// subtract) in the single logic stage between them. Start words and next requests with no
// chunk active return pos_valid low; chunk_last marks the final real position, after which
// the chunk closes until the next start.
module shuffled_index_sequencer_core import sis_pkg::*; #(
  parameter int MAX_CHUNK = MAX_CHUNK_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // chunk_len[8:0], use_new_seed[9], seed_in[41:10]
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // position[8:0]
  output logic [1:0]  out_tuser,  // pos_valid[0], is_decoy[1]
  output logic        out_tlast   // chunk_last
);

  logic              in_valid_r;
  logic              req_r;
  logic [LEN_W-1:0]  len_r;
  logic              new_seed_r;
  logic [SEED_W-1:0] seed_in_r;

  logic [SEED_W-1:0] lfsr_seed_r;
  logic [LEN_W-1:0]  cur_pos_r;
  logic [LEN_W-1:0]  step_size_r;
  logic [LEN_W-1:0]  chunk_size_r;
  logic [LEN_W-1:0]  modulus_prime_r;
  logic [LEN_W-1:0]  real_done_r;
  logic              active_r;

  logic              out_valid_r;
  logic              pos_valid_r;
  logic [LEN_W-1:0]  position_r;
  logic              decoy_r;
  logic              last_r;

  logic              advance;
  logic              fire;
  logic              do_step;
  sis_start_t        start;
  sis_walk_t         walk;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign fire      = in_valid_r && advance;
  assign do_step   = fire && (req_r == REQ_NEXT) && active_r;

  sis_start_calc #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_start (
    .chunk_len    (len_r),
    .use_new_seed (new_seed_r),
    .seed_in      (seed_in_r),
    .seed_cur     (lfsr_seed_r),
    .start        (start)
  );

  sis_walk u_walk (
    .cur_pos       (cur_pos_r),
    .step_size     (step_size_r),
    .chunk_size    (chunk_size_r),
    .modulus_prime (modulus_prime_r),
    .real_done     (real_done_r),
    .walk          (walk)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r      <= in_tuser;
      len_r      <= in_tdata[8:0];
      new_seed_r <= in_tdata[9];
      seed_in_r  <= in_tdata[41:10];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_seed_r     <= '0;
      cur_pos_r       <= '0;
      step_size_r     <= '0;
      chunk_size_r    <= '0;
      modulus_prime_r <= PRIME_BASE;
      real_done_r     <= '0;
      active_r        <= 1'b0;
    end else if (fire && (req_r == REQ_START)) begin
      lfsr_seed_r     <= start.seed;
      cur_pos_r       <= start.pos;
      step_size_r     <= start.step;
      chunk_size_r    <= start.size;
      modulus_prime_r <= start.prime;
      real_done_r     <= '0;
      active_r        <= 1'b1;
    end else if (do_step) begin
      cur_pos_r   <= walk.pos_nxt;
      real_done_r <= walk.done_nxt;
      if (walk.last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pos_valid_r <= do_step;
      position_r  <= do_step ? cur_pos_r : '0;
      decoy_r     <= do_step && walk.decoy;
      last_r      <= do_step && walk.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(16-LEN_W){1'b0}}, position_r};
  assign out_tuser  = {decoy_r, pos_valid_r};
  assign out_tlast  = last_r;

endmodule
